/* sv/otsu_pkg.sv */
`timescale 1ns / 1ps
package otsu_pkg;

  // histogram geometry
  localparam int MAX_BINS = 256;
  localparam int BIN_W    = 8;
  localparam int LOAD_W   = 9;
  localparam int CNT_W    = 24;

  // accumulator widths
  localparam int CC_W = 32;
  localparam int CM_W = 40;
  localparam int SQ_W = 48;

  // wide datapath of the search engine
  localparam int WW   = 208;
  localparam int MA_W = 144;
  localparam int MB_W = 80;
  localparam int Q_W  = 32;

  // configuration port
  localparam int PADDR_W = 3;
  localparam logic REG_BINS_IN_USE = 1'b0;
  localparam logic [LOAD_W-1:0] BINS_RESET = 9'd256;
  localparam logic [LOAD_W-1:0] BINS_MIN   = 9'd2;
  localparam logic [LOAD_W-1:0] BINS_MAX   = 9'd256;

  typedef enum logic [1:0] {
    DIV_F16,
    DIV_F22,
    DIV_F32
  } div_frac_e;

  // one finished histogram handed from loader to search engine
  typedef struct packed {
    logic [CC_W-1:0]  n_total;
    logic [CM_W-1:0]  m_total;
    logic [SQ_W-1:0]  s_total;
    logic [BIN_W-1:0] last;
  } job_t;

  typedef struct packed {
    logic [CC_W-1:0] cc;
    logic [CM_W-1:0] cm;
  } bin_rec_t;

endpackage

/* sv/otsu_histogram_threshold.sv */
`timescale 1ns / 1ps
// Otsu threshold search over a histogram streamed in one bin per word.
// Input channel: bin_count_i words in ascending bin order, one per cycle
// while the loader is free. After bins_in_use words the histogram closes
// and is queued for the search engine; the loader then stalls until the
// engine has finished walking the bin memory; the next histogram may then
// load while the engine finishes its closing multiplies and divisions.
// Output channel: one result word per histogram, held in an output
// register; a stalled receiver holds the word and only blocks the engine
// from releasing its next result.
// Steps: two shift-add multiplies for the totals, then a walk over the
// split levels, plus for every split with both sides non-empty up to six
// multiplies, each ending once its multiplier operand (at most 72 bits)
// has no bits left, then up to four multiplies and up to six restoring
// divisions, which saturate at once when the quotient overflows. All
// multiplies share one shift-add multiplier.
// Reset: accumulators cleared, bins_in_use back to 256, no result pending.
// The bin memory needs no clearing; only bins of the current load are read.
// Config: bins_in_use at byte address 0 of the APB port, written when idle.
module otsu_histogram_threshold (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [otsu_pkg::CNT_W-1:0]          bin_count_i,
  // output channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [8:0]                   sep_level_o,
  output logic [31:0]                         total_count_o,
  output logic [15:0]                         mean_value_o,
  output logic [21:0]                         variance_o,
  output logic [15:0]                         mean_low_o,
  output logic [15:0]                         mean_high_o,
  output logic [21:0]                         between_variance_o,
  output logic [31:0]                         variance_ratio_o,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [otsu_pkg::PADDR_W-1:0]        paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  logic [otsu_pkg::LOAD_W-1:0] bins_q, bins_n;
  logic                        reg_sel;

  // one-entry job queue between loader and search engine
  logic                 job_valid_q;
  otsu_pkg::job_t       job_q, job_push_data;
  logic                 job_push, job_take, scan_busy, hold;

  logic [otsu_pkg::BIN_W-1:0] rd_addr;
  otsu_pkg::bin_rec_t         rd_data;

  // register file, writes complete in the access phase
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == otsu_pkg::REG_BINS_IN_USE);
  assign prdata  = reg_sel ? 32'(bins_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bins_q <= otsu_pkg::BINS_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      bins_q <= pwdata[otsu_pkg::LOAD_W-1:0];
    end
  end

  // out of range settings act as the nearest legal bin count
  always_comb begin
    priority if (bins_q < otsu_pkg::BINS_MIN) begin
      bins_n = otsu_pkg::BINS_MIN;
    end else if (bins_q > otsu_pkg::BINS_MAX) begin
      bins_n = otsu_pkg::BINS_MAX;
    end else begin
      bins_n = bins_q;
    end
  end

  // loader waits while a job is queued or the engine reads the bin memory
  assign hold = job_valid_q || scan_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      job_q       <= '0;
    end else if (job_push) begin
      job_valid_q <= 1'b1;
      job_q       <= job_push_data;
    end else if (job_take) begin
      job_valid_q <= 1'b0;
    end
  end

  otsu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .bin_count_i (bin_count_i),
    .bins_n_i    (bins_n),
    .hold_i      (hold),
    .in_stall_o  (in_stall_o),
    .job_push_o  (job_push),
    .job_o       (job_push_data),
    .rd_addr_i   (rd_addr),
    .rd_data_o   (rd_data)
  );

  otsu_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .job_valid_i        (job_valid_q),
    .job_i              (job_q),
    .job_take_o         (job_take),
    .scan_busy_o        (scan_busy),
    .rd_addr_o          (rd_addr),
    .rd_data_i          (rd_data),
    .out_stall_i        (out_stall_i),
    .out_valid_o        (out_valid_o),
    .sep_level_o        (sep_level_o),
    .total_count_o      (total_count_o),
    .mean_value_o       (mean_value_o),
    .variance_o         (variance_o),
    .mean_low_o         (mean_low_o),
    .mean_high_o        (mean_high_o),
    .between_variance_o (between_variance_o),
    .variance_ratio_o   (variance_ratio_o)
  );

endmodule

/* sv/otsu_front.sv */
`timescale 1ns / 1ps
module otsu_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic [otsu_pkg::CNT_W-1:0]         bin_count_i,
  input  logic [otsu_pkg::LOAD_W-1:0]        bins_n_i,
  input  logic                               hold_i,
  output logic                               in_stall_o,
  output logic                               job_push_o,
  output otsu_pkg::job_t                     job_o,
  input  logic [otsu_pkg::BIN_W-1:0]         rd_addr_i,
  output otsu_pkg::bin_rec_t                 rd_data_o
);

  logic [otsu_pkg::LOAD_W-1:0] loaded_q, loaded_d;
  logic [15:0]                 isq_q, isq_d;
  logic [otsu_pkg::CC_W-1:0]   cc_q, cc_d, cc_new;
  logic [otsu_pkg::CM_W-1:0]   cm_q, cm_d, cm_new;
  logic [otsu_pkg::SQ_W-1:0]   sq_q, sq_d, sq_new;
  logic [otsu_pkg::BIN_W-1:0]  idx;
  logic [31:0]                 mom_inc;
  logic [39:0]                 sq_inc;
  logic [32:0]                 cc_sum;
  logic [40:0]                 cm_sum;
  logic [48:0]                 sq_sum;
  logic [otsu_pkg::LOAD_W-1:0] next_loaded;
  logic                        accept, close;

  otsu_pkg::bin_rec_t mem [otsu_pkg::MAX_BINS];
  otsu_pkg::bin_rec_t rd_q;

  assign idx        = loaded_q[otsu_pkg::BIN_W-1:0];
  assign in_stall_o = hold_i;
  assign accept     = in_valid_i && !hold_i;

  assign mom_inc = 32'(idx) * 32'(bin_count_i);
  assign sq_inc  = 40'(isq_q) * 40'(bin_count_i);

  // saturating running sums
  assign cc_sum = {1'b0, cc_q} + 33'(bin_count_i);
  assign cm_sum = {1'b0, cm_q} + 41'(mom_inc);
  assign sq_sum = {1'b0, sq_q} + 49'(sq_inc);
  assign cc_new = cc_sum[32] ? '1 : cc_sum[31:0];
  assign cm_new = cm_sum[40] ? '1 : cm_sum[39:0];
  assign sq_new = sq_sum[48] ? '1 : sq_sum[47:0];

  assign next_loaded = loaded_q + 9'd1;
  assign close       = next_loaded >= bins_n_i;

  assign job_push_o = accept && close;
  assign job_o      = '{n_total: cc_new, m_total: cm_new, s_total: sq_new, last: idx};

  always_comb begin
    loaded_d = loaded_q;
    isq_d    = isq_q;
    cc_d     = cc_q;
    cm_d     = cm_q;
    sq_d     = sq_q;
    if (accept) begin
      if (close) begin
        loaded_d = '0;
        isq_d    = '0;
        cc_d     = '0;
        cm_d     = '0;
        sq_d     = '0;
      end else begin
        loaded_d = next_loaded;
        // (i+1)^2 = i^2 + 2i + 1
        isq_d    = isq_q + 16'({idx, 1'b0}) + 16'd1;
        cc_d     = cc_new;
        cm_d     = cm_new;
        sq_d     = sq_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= '0;
      isq_q    <= '0;
      cc_q     <= '0;
      cm_q     <= '0;
      sq_q     <= '0;
    end else begin
      loaded_q <= loaded_d;
      isq_q    <= isq_d;
      cc_q     <= cc_d;
      cm_q     <= cm_d;
      sq_q     <= sq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mem[idx] <= '{cc: cc_new, cm: cm_new};
    end
    rd_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_q;

endmodule

/* sv/otsu_mul.sv */
`timescale 1ns / 1ps
module otsu_mul (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [otsu_pkg::MA_W-1:0]   a_i,
  input  logic [otsu_pkg::MB_W-1:0]   b_i,
  output logic [otsu_pkg::WW-1:0]     prod_o,
  output logic                        done_o
);

  logic                        busy_q, done_q;
  logic [otsu_pkg::WW-1:0]     acc_q, a_q;
  logic [otsu_pkg::MB_W-1:0]   b_q;

  // shift-add, ends as soon as no multiplier bits remain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      acc_q  <= '0;
      a_q    <= '0;
      b_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        acc_q  <= '0;
        a_q    <= otsu_pkg::WW'(a_i);
        b_q    <= b_i;
      end else if (busy_q) begin
        if (b_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          if (b_q[0]) begin
            acc_q <= acc_q + a_q;
          end
          a_q <= a_q << 1;
          b_q <= b_q >> 1;
        end
      end
    end
  end

  assign prod_o = acc_q;
  assign done_o = done_q;

endmodule

/* sv/otsu_div.sv */
`timescale 1ns / 1ps
module otsu_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [otsu_pkg::WW-1:0]     num_i,
  input  logic [otsu_pkg::WW-1:0]     den_i,
  input  otsu_pkg::div_frac_e         frac_i,
  output logic [otsu_pkg::Q_W-1:0]    quot_o,
  output logic                        done_o
);

  logic                        busy_q, done_q;
  logic [otsu_pkg::WW-1:0]     rem_q, d_q, den_full, d_init;
  logic [otsu_pkg::Q_W-1:0]    q_q, sat_mask;
  logic [4:0]                  cnt_q, cnt_init;
  logic [5:0]                  nbits;

  always_comb begin
    unique case (frac_i)
      otsu_pkg::DIV_F16: nbits = 6'd16;
      otsu_pkg::DIV_F22: nbits = 6'd22;
      otsu_pkg::DIV_F32: nbits = 6'd32;
      default:           nbits = 6'd16;
    endcase
  end

  assign den_full = den_i << nbits;
  assign d_init   = den_i << (nbits - 6'd1);
  assign cnt_init = 5'(nbits - 6'd1);
  assign sat_mask = (otsu_pkg::Q_W'(1) << cnt_init << 1) - otsu_pkg::Q_W'(1);

  // restoring division, one quotient bit a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      rem_q  <= '0;
      d_q    <= '0;
      q_q    <= '0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (den_i == '0) begin
          q_q    <= '0;
          done_q <= 1'b1;
        end else if (num_i >= den_full) begin
          q_q    <= (nbits == 6'd32) ? '1 : sat_mask;
          done_q <= 1'b1;
        end else begin
          rem_q  <= num_i;
          d_q    <= d_init;
          q_q    <= '0;
          cnt_q  <= cnt_init;
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        if (rem_q >= d_q) begin
          rem_q        <= rem_q - d_q;
          q_q[cnt_q]   <= 1'b1;
        end
        d_q <= d_q >> 1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 5'd1;
        end
      end
    end
  end

  assign quot_o = q_q;
  assign done_o = done_q;

endmodule

/* sv/otsu_back.sv */
`timescale 1ns / 1ps
module otsu_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         job_valid_i,
  input  otsu_pkg::job_t               job_i,
  output logic                         job_take_o,
  output logic                         scan_busy_o,
  output logic [otsu_pkg::BIN_W-1:0]   rd_addr_o,
  input  otsu_pkg::bin_rec_t           rd_data_i,
  input  logic                         out_stall_i,
  output logic                         out_valid_o,
  output logic signed [8:0]            sep_level_o,
  output logic [31:0]                  total_count_o,
  output logic [15:0]                  mean_value_o,
  output logic [21:0]                  variance_o,
  output logic [15:0]                  mean_low_o,
  output logic [15:0]                  mean_high_o,
  output logic [21:0]                  between_variance_o,
  output logic [31:0]                  variance_ratio_o
);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_SN    = 5'd1;
  localparam logic [4:0] ST_MM    = 5'd2;
  localparam logic [4:0] ST_RD    = 5'd3;
  localparam logic [4:0] ST_CHK   = 5'd4;
  localparam logic [4:0] ST_MN    = 5'd5;
  localparam logic [4:0] ST_MC    = 5'd6;
  localparam logic [4:0] ST_DD    = 5'd7;
  localparam logic [4:0] ST_CO    = 5'd8;
  localparam logic [4:0] ST_CMP1  = 5'd9;
  localparam logic [4:0] ST_CMP2  = 5'd10;
  localparam logic [4:0] ST_TAKE  = 5'd11;
  localparam logic [4:0] ST_NN    = 5'd12;
  localparam logic [4:0] ST_BN    = 5'd13;
  localparam logic [4:0] ST_W     = 5'd14;
  localparam logic [4:0] ST_NDND  = 5'd15;
  localparam logic [4:0] ST_DMEAN = 5'd16;
  localparam logic [4:0] ST_DVAR  = 5'd17;
  localparam logic [4:0] ST_DML   = 5'd18;
  localparam logic [4:0] ST_DMH   = 5'd19;
  localparam logic [4:0] ST_DBV   = 5'd20;
  localparam logic [4:0] ST_DRAT  = 5'd21;
  localparam logic [4:0] ST_OUT   = 5'd22;

  localparam int WW   = otsu_pkg::WW;
  localparam int MA_W = otsu_pkg::MA_W;
  localparam int MB_W = otsu_pkg::MB_W;

  logic [4:0] state_q;
  logic       pend_q, scan_q, have_q, out_valid_q;

  // job totals
  logic [31:0]                n_q, nd_q;
  logic [39:0]                mt_q;
  logic [47:0]                s_q;
  logic [otsu_pkg::BIN_W-1:0] last_q, lv_q;

  // per split
  logic [31:0]  c_q, o_q;
  logic [39:0]  m_q;
  logic [WW-1:0] t1_q;
  logic [71:0]  d_q;
  logic [143:0] d2_q;
  logic [63:0]  den_q;

  // best split so far
  logic [143:0]               bd2_q;
  logic [63:0]                bden_q;
  logic [otsu_pkg::BIN_W-1:0] blev_q;
  logic [39:0]                bm_q;
  logic [31:0]                bc_q, bo_q;

  // finals
  logic [79:0]  v_q;
  logic [63:0]  n2_q, nd2_q;
  logic [127:0] bvden_q;
  logic [143:0] w_q;
  logic [15:0]  mean_q, ml_q, mh_q;
  logic [21:0]  var_q, bv_q;
  logic [31:0]  ratio_q;

  // result word register
  logic signed [8:0] o_sep_q;
  logic [31:0]       o_tot_q, o_rat_q;
  logic [15:0]       o_mean_q, o_ml_q, o_mh_q;
  logic [21:0]       o_var_q, o_bv_q;

  logic                        mul_state, div_state, mul_start, div_start;
  logic [MA_W-1:0]             mul_a;
  logic [MB_W-1:0]             mul_b;
  logic [WW-1:0]               prod;
  logic                        mul_done, div_done;
  logic [WW-1:0]               div_num, div_den;
  otsu_pkg::div_frac_e         div_frac;
  logic [otsu_pkg::Q_W-1:0]    quot;
  logic                        out_load;

  always_comb begin
    mul_state = 1'b1;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_q)
      ST_SN:   begin mul_a = MA_W'(s_q);    mul_b = MB_W'(nd_q);   end
      ST_MM:   begin mul_a = MA_W'(mt_q);   mul_b = MB_W'(mt_q);   end
      ST_MN:   begin mul_a = MA_W'(m_q);    mul_b = MB_W'(n_q);    end
      ST_MC:   begin mul_a = MA_W'(mt_q);   mul_b = MB_W'(c_q);    end
      ST_DD:   begin mul_a = MA_W'(d_q);    mul_b = MB_W'(d_q);    end
      ST_CO:   begin mul_a = MA_W'(c_q);    mul_b = MB_W'(o_q);    end
      ST_CMP1: begin mul_a = d2_q;          mul_b = MB_W'(bden_q); end
      ST_CMP2: begin mul_a = bd2_q;         mul_b = MB_W'(den_q);  end
      ST_NN:   begin mul_a = MA_W'(n_q);    mul_b = MB_W'(n_q);    end
      ST_BN:   begin mul_a = MA_W'(n2_q);   mul_b = MB_W'(bden_q); end
      ST_W:    begin mul_a = MA_W'(v_q);    mul_b = MB_W'(bden_q); end
      ST_NDND: begin mul_a = MA_W'(nd_q);   mul_b = MB_W'(nd_q);   end
      default: mul_state = 1'b0;
    endcase
  end

  always_comb begin
    div_state = 1'b1;
    div_num   = '0;
    div_den   = '0;
    div_frac  = otsu_pkg::DIV_F16;
    unique case (state_q)
      ST_DMEAN: begin
        div_num = WW'(mt_q) << 8;
        div_den = WW'(nd_q);
      end
      ST_DVAR: begin
        div_num  = WW'(v_q) << 8;
        div_den  = WW'(nd2_q);
        div_frac = otsu_pkg::DIV_F22;
      end
      ST_DML: begin
        div_num = WW'(bm_q) << 8;
        div_den = WW'(bc_q);
      end
      ST_DMH: begin
        div_num = WW'(mt_q - bm_q) << 8;
        div_den = WW'(bo_q);
      end
      ST_DBV: begin
        div_num  = WW'(bd2_q) << 8;
        div_den  = WW'(bvden_q);
        div_frac = otsu_pkg::DIV_F22;
      end
      ST_DRAT: begin
        div_num  = WW'(bd2_q) << 16;
        div_den  = WW'(w_q - bd2_q);
        div_frac = otsu_pkg::DIV_F32;
      end
      default: div_state = 1'b0;
    endcase
  end

  assign mul_start = mul_state && !pend_q;
  assign div_start = div_state && !pend_q;

  otsu_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .prod_o  (prod),
    .done_o  (mul_done)
  );

  otsu_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .frac_i  (div_frac),
    .quot_o  (quot),
    .done_o  (div_done)
  );

  assign job_take_o  = (state_q == ST_IDLE) && job_valid_i;
  assign scan_busy_o = scan_q;
  assign rd_addr_o   = lv_q;
  assign out_load    = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pend_q      <= 1'b0;
      scan_q      <= 1'b0;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
      n_q <= '0; nd_q <= '0; mt_q <= '0; s_q <= '0; last_q <= '0; lv_q <= '0;
      c_q <= '0; o_q <= '0; m_q <= '0; t1_q <= '0; d_q <= '0; d2_q <= '0; den_q <= '0;
      bd2_q <= '0; bden_q <= '0; blev_q <= '0; bm_q <= '0; bc_q <= '0; bo_q <= '0;
      v_q <= '0; n2_q <= '0; nd2_q <= '0; bvden_q <= '0; w_q <= '0;
      mean_q <= '0; ml_q <= '0; mh_q <= '0; var_q <= '0; bv_q <= '0; ratio_q <= '0;
      o_sep_q <= '0; o_tot_q <= '0; o_rat_q <= '0; o_mean_q <= '0;
      o_ml_q <= '0; o_mh_q <= '0; o_var_q <= '0; o_bv_q <= '0;
    end else begin
      if (mul_start || div_start) begin
        pend_q <= 1'b1;
      end else if (mul_done || div_done) begin
        pend_q <= 1'b0;
      end

      if (out_valid_q && !out_stall_i && !out_load) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (job_valid_i) begin
            n_q     <= job_i.n_total;
            nd_q    <= (job_i.n_total == '0) ? 32'd1 : job_i.n_total;
            mt_q    <= job_i.m_total;
            s_q     <= job_i.s_total;
            last_q  <= job_i.last;
            lv_q    <= '0;
            have_q  <= 1'b0;
            scan_q  <= 1'b1;
            state_q <= ST_SN;
          end
        end
        ST_SN: begin
          if (mul_done) begin
            t1_q    <= prod;
            state_q <= ST_MM;
          end
        end
        ST_MM: begin
          if (mul_done) begin
            // negative overall variance clamps to zero
            v_q     <= (t1_q > prod) ? 80'(t1_q - prod) : '0;
            state_q <= ST_RD;
          end
        end
        ST_RD: begin
          if (lv_q == last_q) begin
            scan_q  <= 1'b0;
            state_q <= have_q ? ST_NN : ST_NDND;
          end else begin
            state_q <= ST_CHK;
          end
        end
        ST_CHK: begin
          c_q <= rd_data_i.cc;
          m_q <= rd_data_i.cm;
          o_q <= n_q - rd_data_i.cc;
          // skip a split with an empty side
          if (rd_data_i.cc == '0 || rd_data_i.cc >= n_q) begin
            lv_q    <= lv_q + 1'b1;
            state_q <= ST_RD;
          end else begin
            state_q <= ST_MN;
          end
        end
        ST_MN: begin
          if (mul_done) begin
            t1_q    <= prod;
            state_q <= ST_MC;
          end
        end
        ST_MC: begin
          if (mul_done) begin
            d_q     <= (t1_q >= prod) ? 72'(t1_q - prod) : 72'(prod - t1_q);
            state_q <= ST_DD;
          end
        end
        ST_DD: begin
          if (mul_done) begin
            d2_q    <= prod[143:0];
            state_q <= ST_CO;
          end
        end
        ST_CO: begin
          if (mul_done) begin
            den_q   <= prod[63:0];
            state_q <= have_q ? ST_CMP1 : ST_TAKE;
          end
        end
        ST_CMP1: begin
          if (mul_done) begin
            t1_q    <= prod;
            state_q <= ST_CMP2;
          end
        end
        ST_CMP2: begin
          if (mul_done) begin
            // later split wins a tie
            if (t1_q >= prod) begin
              state_q <= ST_TAKE;
            end else begin
              lv_q    <= lv_q + 1'b1;
              state_q <= ST_RD;
            end
          end
        end
        ST_TAKE: begin
          have_q  <= 1'b1;
          bd2_q   <= d2_q;
          bden_q  <= den_q;
          blev_q  <= lv_q;
          bm_q    <= m_q;
          bc_q    <= c_q;
          bo_q    <= o_q;
          lv_q    <= lv_q + 1'b1;
          state_q <= ST_RD;
        end
        ST_NN: begin
          if (mul_done) begin
            n2_q    <= prod[63:0];
            state_q <= ST_BN;
          end
        end
        ST_BN: begin
          if (mul_done) begin
            bvden_q <= prod[127:0];
            state_q <= ST_W;
          end
        end
        ST_W: begin
          if (mul_done) begin
            w_q     <= prod[143:0];
            state_q <= ST_NDND;
          end
        end
        ST_NDND: begin
          if (mul_done) begin
            nd2_q   <= prod[63:0];
            state_q <= ST_DMEAN;
          end
        end
        ST_DMEAN: begin
          if (div_done) begin
            mean_q  <= quot[15:0];
            state_q <= ST_DVAR;
          end
        end
        ST_DVAR: begin
          if (div_done) begin
            var_q <= quot[21:0];
            if (have_q) begin
              state_q <= ST_DML;
            end else begin
              ml_q    <= '0;
              mh_q    <= '0;
              bv_q    <= '0;
              ratio_q <= '0;
              state_q <= ST_OUT;
            end
          end
        end
        ST_DML: begin
          if (div_done) begin
            ml_q    <= quot[15:0];
            state_q <= ST_DMH;
          end
        end
        ST_DMH: begin
          if (div_done) begin
            mh_q    <= quot[15:0];
            state_q <= ST_DBV;
          end
        end
        ST_DBV: begin
          if (div_done) begin
            bv_q <= quot[21:0];
            if (w_q > bd2_q) begin
              state_q <= ST_DRAT;
            end else begin
              // within-class variance zero or below
              ratio_q <= (bd2_q == '0) ? '0 : '1;
              state_q <= ST_OUT;
            end
          end
        end
        ST_DRAT: begin
          if (div_done) begin
            ratio_q <= quot;
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            out_valid_q <= 1'b1;
            o_sep_q     <= have_q ? $signed({1'b0, blev_q}) : -9'sd1;
            o_tot_q     <= n_q;
            o_mean_q    <= mean_q;
            o_var_q     <= var_q;
            o_ml_q      <= ml_q;
            o_mh_q      <= mh_q;
            o_bv_q      <= bv_q;
            o_rat_q     <= ratio_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o        = out_valid_q;
  assign sep_level_o        = o_sep_q;
  assign total_count_o      = o_tot_q;
  assign mean_value_o       = o_mean_q;
  assign variance_o         = o_var_q;
  assign mean_low_o         = o_ml_q;
  assign mean_high_o        = o_mh_q;
  assign between_variance_o = o_bv_q;
  assign variance_ratio_o   = o_rat_q;

endmodule
